// ----- hw/rtl/log_interval_subdivider_core_defines.svh -----
// Assertion macros shared by the RTL files of the interval subdivider.
`ifndef LOG_INTERVAL_SUBDIVIDER_CORE_DEFINES_SVH
`define LOG_INTERVAL_SUBDIVIDER_CORE_DEFINES_SVH

`ifndef SYNTH

`define LIS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lis assertion failed");

`define LIS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lis assertion failed");

`else

`define LIS_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define LIS_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/lis_pkg.sv -----
`timescale 1ns / 1ps

package lis_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned LimitBits = 6;

  localparam logic SPLIT_DOUBLING = 1'b0;
  localparam logic SPLIT_BINARY   = 1'b1;

  typedef struct packed {
    logic [FieldBits-1:0] range_first;
    logic [FieldBits-1:0] range_last;
    logic [LimitBits-1:0] max_segments;
    logic                 reverse_order;
  } lis_in_t;

  typedef struct packed {
    logic [FieldBits-1:0] seg_offset;
    logic [FieldBits-1:0] seg_width;
    logic                 is_last;
    logic                 is_empty;
  } lis_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_BIN,
    ST_DBL,
    ST_INS,
    ST_PREP,
    ST_SUM,
    ST_EMIT
  } lis_state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } lis_alu_op_e;

  typedef struct packed {
    lis_state_e state;
    logic       accept;
    logic       emit;
  } lis_ctrl_t;

  typedef struct packed {
    logic empty_req;
    logic bin_done;
    logic dbl_fit;
    logic rem_zero;
    logic ins_move;
    logic need_merge;
    logic sum_done;
    logic emit_last;
  } lis_stat_t;

endpackage

// ----- hw/rtl/log_interval_subdivider_core.sv -----
`timescale 1ns / 1ps
`include "log_interval_subdivider_core_defines.svh"

// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i                   cfg_wdata_i (split method)
// in        in         in_valid_i / in_ready_o    in_data_i (lis_in_t)
// out       out        out_valid_o / out_ready_i  out_data_o (lis_out_t)
//
// A request is accepted, then its widths are found by a bit scan in binary mode or by doubling
// steps plus insertion of the remainder in remainder mode; a setup step follows, then the widths
// to be merged are summed into a merged segment, and each segment is emitted in turn.
// The subtractions and sums share one add/subtract unit; in_ready_o is high only between requests.
// Reset is asynchronous and active low; it clears the sequencer, counters and output valid.
// A stalled output holds its segment and the sequencer waits on it.
module log_interval_subdivider_core #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lis_pkg::lis_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lis_pkg::lis_out_t out_data_o
);
  import lis_pkg::*;

  logic      split_q;
  logic      out_valid_q;
  lis_out_t  out_data_q;
  logic      out_free;
  lis_ctrl_t ctrl;
  lis_stat_t stat;
  lis_out_t  res;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q     <= SPLIT_DOUBLING;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        split_q <= cfg_wdata_i;
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= res;
    end
  end

  lis_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .split_i    (split_q),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  lis_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `LIS_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, ctrl.emit, !out_valid_q || out_ready_i)
  `LIS_ASSERT_IMP(a_empty_is_last, clk_i, rst_ni, out_valid_o && out_data_o.is_empty, out_data_o.is_last && out_data_o.seg_width == '0)

endmodule

// ----- hw/rtl/lis_alu.sv -----
`timescale 1ns / 1ps

module lis_alu #(
  parameter int unsigned Width = 33
) (
  input  lis_pkg::lis_alu_op_e op_i,
  input  logic [Width-1:0]     a_i,
  input  logic [Width-1:0]     b_i,
  output logic [Width-1:0]     res_o,
  output logic                 borrow_o
);
  import lis_pkg::*;

  logic [Width:0] full;

  always_comb begin
    case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o    = full[Width-1:0];
  assign borrow_o = full[Width];

endmodule

// ----- hw/rtl/lis_seq.sv -----
`timescale 1ns / 1ps

module lis_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               split_i,
  input  logic               out_free_i,
  input  lis_pkg::lis_stat_t stat_i,
  output logic               in_ready_o,
  output lis_pkg::lis_ctrl_t ctrl_o
);
  import lis_pkg::*;

  lis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.empty_req) begin
            state_d = ST_EMPTY;
          end else if (split_i == SPLIT_BINARY) begin
            state_d = ST_BIN;
          end else begin
            state_d = ST_DBL;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_BIN: begin
        if (stat_i.bin_done) begin
          state_d = ST_PREP;
        end
      end
      ST_DBL: begin
        if (!stat_i.dbl_fit) begin
          state_d = stat_i.rem_zero ? ST_PREP : ST_INS;
        end
      end
      ST_INS: begin
        if (!stat_i.ins_move) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = stat_i.need_merge ? ST_SUM : ST_EMIT;
      end
      ST_SUM: begin
        if (stat_i.sum_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i && stat_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    ctrl_o.state  = state_q;
    ctrl_o.accept = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.emit   = ((state_q == ST_EMPTY) || (state_q == ST_EMIT)) && out_free_i;
  end

endmodule

// ----- hw/rtl/lis_dp.sv -----
`timescale 1ns / 1ps
`include "log_interval_subdivider_core_defines.svh"

module lis_dp #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lis_pkg::lis_ctrl_t ctrl_i,
  input  lis_pkg::lis_in_t   in_data_i,
  output lis_pkg::lis_stat_t stat_o,
  output lis_pkg::lis_out_t  res_o
);
  import lis_pkg::*;

  localparam int unsigned CntBits  = $clog2(INDEX_BITS + 1);
  localparam int unsigned AddrBits = $clog2(INDEX_BITS);
  localparam int unsigned AluBits  = INDEX_BITS + 1;
  localparam int unsigned CmpBits  = LimitBits + 1;

  logic [INDEX_BITS-1:0] seg_q [INDEX_BITS];

  logic [INDEX_BITS-1:0] off_q, off_d;
  logic [INDEX_BITS-1:0] rem_q, rem_d;
  logic [INDEX_BITS:0]   step_q, step_d;
  logic [INDEX_BITS-1:0] sum_q, sum_d;
  logic [LimitBits-1:0]  limit_q, limit_d;
  logic                  rev_q, rev_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [CntBits-1:0]    pos_q, pos_d;
  logic [CntBits-1:0]    drop_q, drop_d;
  logic [CntBits-1:0]    ptr_q, ptr_d;
  logic [CntBits-1:0]    arr_left_q, arr_left_d;
  logic [CntBits-1:0]    items_left_q, items_left_d;
  logic                  sum_pend_q, sum_pend_d;

  lis_alu_op_e           alu_op;
  logic [AluBits-1:0]    alu_a, alu_b, alu_res;
  logic                  alu_borrow;

  logic [AddrBits-1:0]   rd_addr, pos_addr, wr_addr;
  logic [INDEX_BITS-1:0] rd_data, wr_data;
  logic                  wr_en;

  logic [CntBits-1:0]    pos_m1, cnt_m1, drop_m1;
  logic [INDEX_BITS-1:0] diff, w_in, emit_width, off_nxt;
  logic [LimitBits-1:0]  limit_in;
  logic [CmpBits-1:0]    drop_w;
  logic                  take_sum;

  assign pos_addr = pos_q[AddrBits-1:0];
  assign pos_m1   = pos_q - CntBits'(1);
  assign cnt_m1   = cnt_q - CntBits'(1);
  assign drop_m1  = drop_q - CntBits'(1);

  always_comb begin
    case (ctrl_i.state)
      ST_INS:  rd_addr = pos_m1[AddrBits-1:0];
      ST_EMIT: rd_addr = ptr_q[AddrBits-1:0];
      default: rd_addr = pos_addr;
    endcase
  end

  assign rd_data = seg_q[rd_addr];

  always_comb begin
    case (ctrl_i.state)
      ST_IDLE: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, in_data_i.range_last[INDEX_BITS-1:0]};
        alu_b  = {1'b0, in_data_i.range_first[INDEX_BITS-1:0]};
      end
      ST_DBL: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, rem_q};
        alu_b  = step_q;
      end
      ST_INS: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, rem_q};
        alu_b  = {1'b0, rd_data};
      end
      ST_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = {1'b0, sum_q};
        alu_b  = {1'b0, rd_data};
      end
      ST_EMIT: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, sum_q};
        alu_b  = {1'b0, rd_data};
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  lis_alu #(
    .Width (AluBits)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  assign diff     = alu_res[INDEX_BITS-1:0];
  assign w_in     = diff + INDEX_BITS'(1);
  assign limit_in = (in_data_i.max_segments == '0) ? LimitBits'(1) : in_data_i.max_segments;
  assign drop_w   = CmpBits'(cnt_q) - CmpBits'(limit_q) + CmpBits'(1);

  assign take_sum   = sum_pend_q &&
                      ((arr_left_q == '0) || (rev_q ? !alu_borrow : alu_borrow));
  assign emit_width = take_sum ? sum_q : rd_data;
  assign off_nxt    = off_q + emit_width;

  always_comb begin
    stat_o.empty_req  = alu_borrow || (&diff);
    stat_o.bin_done   = (pos_q == CntBits'(INDEX_BITS - 1));
    stat_o.dbl_fit    = !alu_borrow;
    stat_o.rem_zero   = (rem_q == '0);
    stat_o.ins_move   = (pos_q != '0) && alu_borrow;
    stat_o.need_merge = (CmpBits'(cnt_q) > CmpBits'(limit_q));
    stat_o.sum_done   = (pos_q == drop_m1);
    stat_o.emit_last  = (items_left_q == CntBits'(1));
  end

  always_comb begin
    res_o = '0;
    case (ctrl_i.state)
      ST_EMPTY: begin
        res_o.is_last  = 1'b1;
        res_o.is_empty = 1'b1;
      end
      ST_EMIT: begin
        res_o.seg_offset = FieldBits'(off_q);
        res_o.seg_width  = FieldBits'(emit_width);
        res_o.is_last    = stat_o.emit_last;
      end
      default: res_o = '0;
    endcase
  end

  always_comb begin
    off_d        = off_q;
    rem_d        = rem_q;
    step_d       = step_q;
    sum_d        = sum_q;
    limit_d      = limit_q;
    rev_d        = rev_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    drop_d       = drop_q;
    ptr_d        = ptr_q;
    arr_left_d   = arr_left_q;
    items_left_d = items_left_q;
    sum_pend_d   = sum_pend_q;
    wr_en        = 1'b0;
    wr_addr      = cnt_q[AddrBits-1:0];
    wr_data      = '0;
    case (ctrl_i.state)
      ST_IDLE: begin
        if (ctrl_i.accept) begin
          off_d   = in_data_i.range_first[INDEX_BITS-1:0];
          rem_d   = w_in;
          step_d  = AluBits'(1);
          limit_d = limit_in;
          rev_d   = in_data_i.reverse_order;
          cnt_d   = '0;
          pos_d   = '0;
        end
      end
      ST_BIN: begin
        if (rem_q[pos_addr]) begin
          wr_en   = 1'b1;
          wr_data = INDEX_BITS'(1) << pos_q;
          cnt_d   = cnt_q + CntBits'(1);
        end
        pos_d = pos_q + CntBits'(1);
      end
      ST_DBL: begin
        if (!alu_borrow) begin
          wr_en   = 1'b1;
          wr_data = step_q[INDEX_BITS-1:0];
          cnt_d   = cnt_q + CntBits'(1);
          rem_d   = alu_res[INDEX_BITS-1:0];
          step_d  = step_q << 1;
        end else if (rem_q != '0) begin
          pos_d = cnt_q;
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos_addr;
        if (stat_o.ins_move) begin
          wr_data = rd_data;
          pos_d   = pos_m1;
        end else begin
          wr_data = rem_q;
        end
      end
      ST_PREP: begin
        if (stat_o.need_merge) begin
          drop_d       = drop_w[CntBits-1:0];
          items_left_d = limit_q[CntBits-1:0];
          arr_left_d   = cnt_q - drop_w[CntBits-1:0];
          sum_pend_d   = 1'b1;
          sum_d        = '0;
          pos_d        = '0;
          ptr_d        = rev_q ? cnt_m1 : drop_w[CntBits-1:0];
        end else begin
          items_left_d = cnt_q;
          arr_left_d   = cnt_q;
          sum_pend_d   = 1'b0;
          ptr_d        = rev_q ? cnt_m1 : '0;
        end
      end
      ST_SUM: begin
        sum_d = alu_res[INDEX_BITS-1:0];
        pos_d = pos_q + CntBits'(1);
      end
      ST_EMIT: begin
        if (ctrl_i.emit) begin
          off_d        = off_nxt;
          items_left_d = items_left_q - CntBits'(1);
          if (take_sum) begin
            sum_pend_d = 1'b0;
          end else begin
            arr_left_d = arr_left_q - CntBits'(1);
            ptr_d      = rev_q ? (ptr_q - CntBits'(1)) : (ptr_q + CntBits'(1));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pos_q        <= '0;
      drop_q       <= '0;
      ptr_q        <= '0;
      arr_left_q   <= '0;
      items_left_q <= '0;
      sum_pend_q   <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      drop_q       <= drop_d;
      ptr_q        <= ptr_d;
      arr_left_q   <= arr_left_d;
      items_left_q <= items_left_d;
      sum_pend_q   <= sum_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    sum_q   <= sum_d;
    limit_q <= limit_d;
    rev_q   <= rev_d;
    if (wr_en) begin
      seg_q[wr_addr] <= wr_data;
    end
  end

  // During emission, the segments still owed equal the stored widths left plus the pending merged width.
  `LIS_ASSERT_IMP(a_emit_count, clk_i, rst_ni, ctrl_i.state == ST_EMIT, items_left_q == arr_left_q + CntBits'(sum_pend_q))
  `LIS_ASSERT_IMP(a_ins_in_range, clk_i, rst_ni, ctrl_i.state == ST_INS, pos_q < cnt_q)
  `LIS_ASSERT_NXT(a_last_drains, clk_i, rst_ni, ctrl_i.state == ST_EMIT && ctrl_i.emit && stat_o.emit_last, items_left_q == '0 && !sum_pend_q)

endmodule

// ----- tb/sv/tb_log_interval_subdivider_core.sv -----
`timescale 1ns / 1ps

module tb_log_interval_subdivider_core;
  import lis_pkg::*;

  localparam int unsigned INDEX_BITS   = 32;
  localparam logic [63:0] INDEX_MASK   = (64'd1 << INDEX_BITS) - 64'd1;
  localparam int          DRAIN_CYCLES = 120;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          RANDOM_PER_PHASE = 11;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lis_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lis_out_t out_data;

  lis_in_t  pending_reqs[$];
  lis_out_t exp_segments[$];
  logic     split_model = SPLIT_DOUBLING;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_trigger = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;

  log_interval_subdivider_core #(
    .INDEX_BITS(INDEX_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  function automatic void predict_segments(lis_in_t req);
    logic [63:0] widths[$];
    logic [63:0] first;
    logic [63:0] last;
    logic [63:0] span;
    logic [63:0] step;
    logic [63:0] rem;
    logic [63:0] total;
    logic [63:0] offset;
    logic [63:0] sw;
    int          limit;
    int          drop;
    int          n;
    lis_out_t    seg;
    first = {32'b0, req.range_first} & INDEX_MASK;
    last  = {32'b0, req.range_last} & INDEX_MASK;
    span  = (last - first + 64'd1) & INDEX_MASK;
    seg   = '0;
    if (last < first || span == 64'd0) begin
      seg.is_last  = 1'b1;
      seg.is_empty = 1'b1;
      exp_segments.push_back(seg);
      return;
    end
    limit = (req.max_segments == '0) ? 1 : int'(req.max_segments);
    if (split_model == SPLIT_BINARY) begin
      for (int i = 0; i < INDEX_BITS; i++) begin
        if (span[i]) widths.push_back(64'd1 << i);
      end
    end else begin
      step = 64'd1;
      rem  = span;
      while (step <= rem) begin
        widths.push_back(step);
        rem  = rem - step;
        step = step << 1;
      end
      if (rem > 64'd0) widths.push_back(rem);
      widths.sort();
    end
    n = widths.size();
    if (n > limit) begin
      drop  = n - limit + 1;
      total = 64'd0;
      for (int i = 0; i < drop; i++) total = total + widths.pop_front();
      widths.push_back(total);
      widths.sort();
      n = widths.size();
    end
    offset = first;
    for (int k = 0; k < n; k++) begin
      sw = req.reverse_order ? widths[n - 1 - k] : widths[k];
      seg.seg_offset = offset[31:0];
      seg.seg_width  = sw[31:0];
      seg.is_last    = (k == n - 1);
      seg.is_empty   = 1'b0;
      exp_segments.push_back(seg);
      offset = (offset + sw) & INDEX_MASK;
    end
  endfunction

  function automatic lis_in_t random_request();
    lis_in_t     req;
    logic [31:0] span;
    int          kind;
    kind = $urandom_range(99);
    span = 32'd1;
    req.range_first = $urandom();
    req.range_last  = $urandom();
    if (kind < 75) begin
      if (kind < 35) span = $urandom_range(1, 64);
      else if (kind < 55) span = $urandom_range(1, 32'h0001_0000);
      else span = $urandom_range(1, 32'hFFFF_FFFF);
      req.range_first = $urandom_range(0, 32'hFFFF_FFFF - span + 32'd1);
      req.range_last  = req.range_first + span - 32'd1;
    end else if (kind < 83) begin
      req.range_first = $urandom_range(0, 15);
      req.range_last  = 32'hFFFF_FFFF - $urandom_range(0, 15);
    end else if (kind < 93) begin
      if (req.range_first == 32'd0) req.range_first = 32'd1;
      req.range_last = $urandom_range(0, req.range_first - 32'd1);
    end
    if ($urandom_range(99) < 70) req.max_segments = $urandom_range(0, 32);
    else req.max_segments = $urandom_range(0, 63);
    req.reverse_order = $urandom_range(0, 1);
    return req;
  endfunction

  task automatic queue_request(logic [31:0] first, logic [31:0] last, logic [5:0] limit,
                               logic rev);
    lis_in_t req;
    req.range_first   = first;
    req.range_last    = last;
    req.max_segments  = limit;
    req.reverse_order = rev;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || exp_segments.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_split(logic value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    split_model = value;
  endtask

  task automatic queue_directed();
    queue_request(32'd0, 32'd0, 6'd32, 1'b0);
    queue_request(32'd0, 32'hFFFF_FFFF, 6'd32, 1'b0);
    queue_request(32'd5, 32'd4, 6'd4, 1'b1);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b1);
    queue_request(32'd0, 32'hFFFF_FFFE, 6'd32, 1'b0);
    queue_request(32'd0, 32'hFFFF_FFFE, 6'd0, 1'b1);
    queue_request(32'd100, 32'd1099, 6'd3, 1'b1);
    queue_request(32'h8000_0000, 32'hFFFF_FFFF, 6'd63, 1'b0);
    queue_request(32'd1, 32'hFFFF_FFFF, 6'd32, 1'b1);
    queue_request(32'h1234_5678, 32'h9ABC_DEF0, 6'd1, 1'b0);
    queue_request(32'hFFFF_FFFF, 32'd0, 6'd63, 1'b0);
    queue_request(32'd10, 32'd15, 6'd2, 1'b1);
  endtask

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_segments(in_data);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lis_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_segments.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = exp_segments.pop_front();
        if (out_data.seg_offset !== want.seg_offset)
          report_mismatch($sformatf("seg_offset got %h expected %h",
                                    out_data.seg_offset, want.seg_offset));
        if (out_data.seg_width !== want.seg_width)
          report_mismatch($sformatf("seg_width got %h expected %h",
                                    out_data.seg_width, want.seg_width));
        if (out_data.is_last !== want.is_last)
          report_mismatch($sformatf("is_last got %b expected %b",
                                    out_data.is_last, want.is_last));
        if (out_data.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty got %b expected %b",
                                    out_data.is_empty, want.is_empty));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int send_modes[4];
    int recv_modes[4];
    send_modes = '{0, 75, 0, 18};
    recv_modes = '{0, 0, 75, 18};
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    write_split(SPLIT_BINARY);
    queue_directed();
    wait_idle();
    write_split(SPLIT_DOUBLING);
    queue_directed();
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      write_split((phase % 2 == 0) ? SPLIT_BINARY : SPLIT_DOUBLING);
      send_idle_pct  = send_modes[(phase / 2) % 4];
      recv_stall_pct = recv_modes[(phase / 2) % 4];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_reqs.push_back(random_request());
      if (phase == 0 || phase == 5) hold_trigger++;
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
